/* rtl/rmq_pkg.sv */
// ============================================================================
// rmq_pkg
// Shared types and codes for the rotation matrix to quaternion converter.
// ============================================================================
`default_nettype none

package rmq_pkg;

  // output slot codes: which quaternion part carries the half root
  localparam logic [1:0] SLOT_W = 2'd0;
  localparam logic [1:0] SLOT_X = 2'd1;
  localparam logic [1:0] SLOT_Y = 2'd2;
  localparam logic [1:0] SLOT_Z = 2'd3;

  // classification result that travels with each request
  typedef struct packed {
    logic [1:0] root_sel;  // slot that gets the half root
    logic       zero;      // whole quaternion is zero
    logic       degen;     // radicand was negative and clamped
  } ctl_t;

endpackage

`default_nettype wire

/* rtl/rmq_front.sv */
// ============================================================================
// rmq_front
// Accepts a matrix, picks the branch and pivot, forms radicand and the three
// off-diagonal terms, and holds them in one register stage.
// ============================================================================
`default_nettype none

module rmq_front import rmq_pkg::*; #(
  parameter int W  = 16,
  parameter int F  = 14,
  parameter int RW = 18
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  valid_i,
  output logic                       ready_o,
  input  wire logic [8:0][W-1:0]     mat_i,
  output logic                       valid_o,
  input  wire logic                  ready_i,
  output logic [RW-1:0]              rad_o,
  output logic [2:0][W:0]            d_o,
  output ctl_t                       ctl_o
);

  localparam int RS = RW + 1;
  localparam int DW = W + 1;
  localparam logic signed [RS-1:0] ONE = RS'(1) << F;

  logic signed [RS-1:0] e [9];
  logic signed [DW-1:0] m [9];
  logic signed [RS-1:0] tr, rad_s;
  logic                 trpos, sel1, sel2;
  logic signed [RS-1:0] piv1;
  logic [1:0]           isel;
  logic [RW-1:0]        rad_d;
  logic [2:0][W:0]      d_d;
  ctl_t                 ctl_d;

  logic                 v_q;
  logic [RW-1:0]        rad_q;
  logic [2:0][W:0]      d_q;
  ctl_t                 ctl_q;

  // widen elements
  always_comb begin
    for (int k = 0; k < 9; k++) begin
      e[k] = RS'($signed(mat_i[k]));
      m[k] = DW'($signed(mat_i[k]));
    end
  end

  // branch and pivot choice
  always_comb begin
    tr    = e[0] + e[4] + e[8];
    trpos = !tr[RS-1] && (tr != '0);
    sel1  = e[4] > e[0];
    piv1  = sel1 ? e[4] : e[0];
    sel2  = e[8] > piv1;
    isel  = sel2 ? 2'd2 : (sel1 ? 2'd1 : 2'd0);
  end

  // radicand and terms per branch
  always_comb begin
    ctl_d = '0;
    rad_s = '0;
    d_d   = '0;
    if (trpos) begin
      rad_s          = tr + ONE;
      ctl_d.root_sel = SLOT_W;
      d_d[0] = m[5] - m[7];
      d_d[1] = m[6] - m[2];
      d_d[2] = m[1] - m[3];
    end else begin
      unique case (isel)
        2'd1: begin
          rad_s          = e[4] - e[8] - e[0] + ONE;
          ctl_d.root_sel = SLOT_Y;
          d_d[0] = m[6] - m[2];
          d_d[1] = m[3] + m[1];
          d_d[2] = m[5] + m[7];
        end
        2'd2: begin
          rad_s          = e[8] - e[0] - e[4] + ONE;
          ctl_d.root_sel = SLOT_Z;
          d_d[0] = m[1] - m[3];
          d_d[1] = m[6] + m[2];
          d_d[2] = m[7] + m[5];
        end
        default: begin
          rad_s          = e[0] - e[4] - e[8] + ONE;
          ctl_d.root_sel = SLOT_X;
          d_d[0] = m[5] - m[7];
          d_d[1] = m[1] + m[3];
          d_d[2] = m[2] + m[6];
        end
      endcase
      ctl_d.degen = rad_s[RS-1];
      ctl_d.zero  = rad_s[RS-1] || (rad_s == '0);
    end
    rad_d = rad_s[RS-1] ? '0 : rad_s[RW-1:0];
  end

  assign ready_o = !v_q || ready_i;

  // front register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      rad_q <= rad_d;
      d_q   <= d_d;
      ctl_q <= ctl_d;
    end
  end

  assign valid_o = v_q;
  assign rad_o   = rad_q;
  assign d_o     = d_q;
  assign ctl_o   = ctl_q;

endmodule

`default_nettype wire

/* rtl/rmq_fifo.sv */
// ============================================================================
// rmq_fifo
// Short queue between the classifying front and the arithmetic back end.
// ============================================================================
`default_nettype none

module rmq_fifo #(
  parameter int WIDTH = 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  output logic                  full_o,
  input  wire logic             pop_i,
  output logic [WIDTH-1:0]      rdata_o,
  output logic                  empty_o
);

  localparam int DEPTH = 4;
  localparam int AW    = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wp_q, rp_q;
  logic [AW:0]      cnt_q;

  assign full_o  = cnt_q == (AW+1)'(DEPTH);
  assign empty_o = cnt_q == '0;
  assign rdata_o = mem_q[rp_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wp_q <= wp_q + 1'b1;
      if (pop_i)  rp_q <= rp_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (!push_i && pop_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wp_q] <= wdata_i;
  end

endmodule

`default_nettype wire

/* rtl/rmq_sqrt.sv */
// ============================================================================
// rmq_sqrt
// Pipelined integer square root, one result bit per stage, with sideband.
// ============================================================================
`default_nettype none

module rmq_sqrt #(
  parameter int NB = 16,
  parameter int SW = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [2*NB-1:0] x_i,
  input  wire logic [SW-1:0]   side_i,
  output logic                 valid_o,
  output logic [NB-1:0]        root_o,
  output logic [SW-1:0]        side_o
);

  localparam int RMW = NB + 3;

  logic            v_q    [NB];
  logic [RMW-1:0]  rem_q  [NB];
  logic [NB-1:0]   root_q [NB];
  logic [2*NB-1:0] x_q    [NB];
  logic [SW-1:0]   sd_q   [NB];

  for (genvar g = 0; g < NB; g++) begin : g_stage
    logic            v_p;
    logic [RMW-1:0]  rem_p;
    logic [NB-1:0]   root_p;
    logic [2*NB-1:0] x_p;
    logic [SW-1:0]   sd_p;
    logic [RMW-1:0]  r2, trial;
    logic            ge;

    if (g == 0) begin : g_in
      assign v_p    = valid_i;
      assign rem_p  = '0;
      assign root_p = '0;
      assign x_p    = x_i;
      assign sd_p   = side_i;
    end else begin : g_mid
      assign v_p    = v_q[g-1];
      assign rem_p  = rem_q[g-1];
      assign root_p = root_q[g-1];
      assign x_p    = x_q[g-1];
      assign sd_p   = sd_q[g-1];
    end

    // bring down two bits and try the next root bit
    assign r2    = {rem_p[RMW-3:0], x_p[2*NB-1 -: 2]};
    assign trial = {1'b0, root_p, 2'b01};
    assign ge    = r2 >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= ge ? (r2 - trial) : r2;
        root_q[g] <= {root_p[NB-2:0], ge};
        x_q[g]    <= {x_p[2*NB-3:0], 2'b00};
        sd_q[g]   <= sd_p;
      end
    end
  end

  assign valid_o = v_q[NB-1];
  assign root_o  = root_q[NB-1];
  assign side_o  = sd_q[NB-1];

endmodule

`default_nettype wire

/* rtl/rmq_div.sv */
// ============================================================================
// rmq_div
// Three-lane pipelined restoring divider: round(|d| * 2^F / (2 s)), one
// quotient bit per stage, with sign and root carried along.
// ============================================================================
`default_nettype none

module rmq_div import rmq_pkg::*; #(
  parameter int NB = 16,
  parameter int NW = 32,
  parameter int DW = 17,
  parameter int F  = 14
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            en_i,
  input  wire logic            valid_i,
  input  wire logic [NB-1:0]   root_i,
  input  wire logic [2:0][DW-1:0] d_i,
  input  wire ctl_t            ctl_i,
  output logic                 valid_o,
  output logic [2:0][NW-1:0]   quo_o,
  output logic [2:0]           neg_o,
  output logic [NB-1:0]        root_o,
  output ctl_t                 ctl_o
);

  localparam int RMW = NB + 2;

  // prep stage
  logic            pv_q;
  logic [2:0][NW-1:0] pn_q;
  logic [2:0]      pneg_q;
  logic [NB-1:0]   proot_q;
  ctl_t            pctl_q;
  logic [2:0][NW-1:0] pn_d;
  logic [DW-1:0]   mag;

  // numerator with rounding half added in
  always_comb begin
    mag  = '0;
    pn_d = '0;
    for (int l = 0; l < 3; l++) begin
      mag     = d_i[l][DW-1] ? (~d_i[l] + 1'b1) : d_i[l];
      pn_d[l] = (NW'(mag) << F) + NW'(root_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pv_q <= 1'b0;
    end else if (en_i) begin
      pv_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pn_q    <= pn_d;
      proot_q <= root_i;
      pctl_q  <= ctl_i;
      for (int l = 0; l < 3; l++) pneg_q[l] <= d_i[l][DW-1];
    end
  end

  // division stages
  logic               v_q    [NW];
  logic [2:0][RMW-1:0] rem_q [NW];
  logic [2:0][NW-1:0] n_q    [NW];
  logic [2:0][NW-1:0] q_q    [NW];
  logic [2:0]         neg_q  [NW];
  logic [NB-1:0]      root_q [NW];
  ctl_t               ctl_q  [NW];

  for (genvar g = 0; g < NW; g++) begin : g_stage
    logic               v_p;
    logic [2:0][RMW-1:0] rem_p;
    logic [2:0][NW-1:0] n_p, q_p;
    logic [2:0]         neg_p;
    logic [NB-1:0]      root_p;
    ctl_t               ctl_p;
    logic [2:0][RMW-1:0] rem_n;
    logic [2:0][NW-1:0] q_n, n_n;
    logic [RMW-1:0]     dvs, r2;
    logic               ge;

    if (g == 0) begin : g_in
      assign v_p    = pv_q;
      assign rem_p  = '0;
      assign n_p    = pn_q;
      assign q_p    = '0;
      assign neg_p  = pneg_q;
      assign root_p = proot_q;
      assign ctl_p  = pctl_q;
    end else begin : g_mid
      assign v_p    = v_q[g-1];
      assign rem_p  = rem_q[g-1];
      assign n_p    = n_q[g-1];
      assign q_p    = q_q[g-1];
      assign neg_p  = neg_q[g-1];
      assign root_p = root_q[g-1];
      assign ctl_p  = ctl_q[g-1];
    end

    // shift in one numerator bit and compare against twice the root
    always_comb begin
      dvs   = {1'b0, root_p, 1'b0};
      r2    = '0;
      ge    = 1'b0;
      rem_n = '0;
      q_n   = '0;
      n_n   = '0;
      for (int l = 0; l < 3; l++) begin
        r2       = {rem_p[l][RMW-2:0], n_p[l][NW-1]};
        ge       = r2 >= dvs;
        rem_n[l] = ge ? (r2 - dvs) : r2;
        q_n[l]   = {q_p[l][NW-2:0], ge};
        n_n[l]   = {n_p[l][NW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[g] <= 1'b0;
      end else if (en_i) begin
        v_q[g] <= v_p;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g]  <= rem_n;
        n_q[g]    <= n_n;
        q_q[g]    <= q_n;
        neg_q[g]  <= neg_p;
        root_q[g] <= root_p;
        ctl_q[g]  <= ctl_p;
      end
    end
  end

  assign valid_o = v_q[NW-1];
  assign quo_o   = q_q[NW-1];
  assign neg_o   = neg_q[NW-1];
  assign root_o  = root_q[NW-1];
  assign ctl_o   = ctl_q[NW-1];

endmodule

`default_nettype wire

/* rtl/rotation_matrix_to_quaternion.sv */
// NB is the root width (one bit per root stage) and NW the quotient width (one bit
//   per divider stage); a four-entry queue sits before the back end
// throughput: one request per cycle, set by the fully pipelined root and divider,
//   while the output is not stalled by m_axis_tready
// reset: rst_ni is asynchronous, active low, and empties every stage and the queue
// ============================================================================
// rotation_matrix_to_quaternion
// Shepperd conversion of a fixed-point 3x3 rotation matrix to a quaternion.
// ============================================================================
`default_nettype none

module rotation_matrix_to_quaternion import rmq_pkg::*; #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic s_axis_tvalid,
  output logic      s_axis_tready,
  // m00, m01, m02, m10, m11, m12, m20, m21, m22 from the lowest bit up
  input  wire logic [((9*DATA_WIDTH+7)/8)*8-1:0] s_axis_tdata,
  output logic      m_axis_tvalid,
  input  wire logic m_axis_tready,
  // quat_w, quat_x, quat_y, quat_z from the lowest bit up
  output logic [((4*DATA_WIDTH+7)/8)*8-1:0] m_axis_tdata,
  // degenerate
  output logic [0:0] m_axis_tuser
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int RW  = ((W > F + 1) ? W : F + 1) + 2;
  localparam int NB  = (RW + F + 1) / 2;
  localparam int DW  = W + 1;
  localparam int NW  = ((W + 1 + F > NB) ? W + 1 + F : NB) + 1;
  localparam int ODW = ((4*W+7)/8)*8;
  localparam int CW  = NB + NW + W;
  localparam int CTW = $bits(ctl_t);
  localparam int FW  = RW + 3*DW + CTW;
  localparam int SW  = 3*DW + CTW;
  localparam logic [CW-1:0] HI = CW'((64'd1 << (W-1)) - 64'd1);

  // front
  logic [8:0][W-1:0] mat;
  logic              fv, fready;
  logic [RW-1:0]     frad;
  logic [2:0][W:0]   fd;
  ctl_t              fctl;

  always_comb begin
    for (int k = 0; k < 9; k++) mat[k] = s_axis_tdata[k*W +: W];
  end

  rmq_front #(.W(W), .F(F), .RW(RW)) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (s_axis_tvalid),
    .ready_o (s_axis_tready),
    .mat_i   (mat),
    .valid_o (fv),
    .ready_i (fready),
    .rad_o   (frad),
    .d_o     (fd),
    .ctl_o   (fctl)
  );

  // queue
  logic          q_full, q_empty, q_pop, en;
  logic [FW-1:0] q_rdata;

  assign fready = !q_full;
  assign en     = !m_axis_tvalid || m_axis_tready;
  assign q_pop  = en && !q_empty;

  rmq_fifo #(.WIDTH(FW)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fv && !q_full),
    .wdata_i ({frad, fd, fctl}),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .rdata_o (q_rdata),
    .empty_o (q_empty)
  );

  // square root
  logic [RW-1:0]   b_rad;
  logic [SW-1:0]   b_side, s_side;
  logic            s_valid;
  logic [NB-1:0]   s_root;
  logic [2:0][W:0] s_d;
  ctl_t            s_ctl;

  assign b_rad  = q_rdata[FW-1 -: RW];
  assign b_side = q_rdata[SW-1:0];

  rmq_sqrt #(.NB(NB), .SW(SW)) u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (!q_empty),
    .x_i     ((2*NB)'({b_rad, {F{1'b0}}})),
    .side_i  (b_side),
    .valid_o (s_valid),
    .root_o  (s_root),
    .side_o  (s_side)
  );

  assign {s_d, s_ctl} = s_side;

  // division
  logic               dv_valid;
  logic [2:0][NW-1:0] dv_quo;
  logic [2:0]         dv_neg;
  logic [NB-1:0]      dv_root;
  ctl_t               dv_ctl;

  rmq_div #(.NB(NB), .NW(NW), .DW(DW), .F(F)) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s_valid),
    .root_i  (s_root),
    .d_i     (s_d),
    .ctl_i   (s_ctl),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .neg_o   (dv_neg),
    .root_o  (dv_root),
    .ctl_o   (dv_ctl)
  );

  // rounding, sign, saturation and slot placement
  logic [W-1:0]      lane_sat [3];
  logic [W-1:0]      half_sat;
  logic [CW-1:0]     half_w, qw;
  logic [3:0][W-1:0] quat;
  logic [1:0]        lane;

  always_comb begin
    half_w = (CW'(dv_root) + CW'(1)) >> 1;
    half_sat = (half_w > HI) ? HI[W-1:0] : half_w[W-1:0];
    qw = '0;
    for (int l = 0; l < 3; l++) begin
      qw = CW'(dv_quo[l]);
      if (dv_neg[l]) begin
        lane_sat[l] = (qw > HI + CW'(1)) ? ~HI[W-1:0] : (~qw[W-1:0] + 1'b1);
      end else begin
        lane_sat[l] = (qw > HI) ? HI[W-1:0] : qw[W-1:0];
      end
    end
    lane = '0;
    quat = '0;
    for (int s = 0; s < 4; s++) begin
      lane = 2'(s) - ((2'(s) > dv_ctl.root_sel) ? 2'd1 : 2'd0);
      if (dv_ctl.zero) quat[s] = '0;
      else if (2'(s) == dv_ctl.root_sel) quat[s] = half_sat;
      else quat[s] = lane_sat[lane];
    end
  end

  // output register
  logic [ODW-1:0] tdata_q;
  logic           tvalid_q, degen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tvalid_q <= 1'b0;
    end else if (en) begin
      tvalid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en && dv_valid) begin
      tdata_q <= ODW'(quat);
      degen_q <= dv_ctl.degen;
    end
  end

  assign m_axis_tvalid   = tvalid_q;
  assign m_axis_tdata    = tdata_q;
  assign m_axis_tuser[0] = degen_q;

  // checks
  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[4*W-1:0] == '0)
    else $error("degenerate result with nonzero quaternion");

  a_front_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> fv && q_full)
    else $error("input stalled while front stage could move");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> !q_empty && en)
    else $error("queue popped while empty or stalled");

endmodule

`default_nettype wire
